@@ design/tlpqs_pkg.sv @@
// Shared types and constants of the two-level preemptive queue scheduler.
package tlpqs_pkg;

  localparam int unsigned NUM_PROCS_DEF = 16;
  localparam int unsigned ID_W          = 4;
  localparam int unsigned BURST_W       = 16;
  localparam int unsigned TIME_W        = 32;

  // request kinds
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // process classes
  localparam logic CLS_SYS = 1'b0;
  localparam logic CLS_USR = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_TICK   = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic [ID_W-1:0]    proc_id;
    logic [BURST_W-1:0] burst;
    logic               proc_class;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              idle;
    logic [ID_W-1:0]   run_id;
    logic              done_res;
    logic [ID_W-1:0]   done_id;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] wait_time;
  } res_t;

  // one process table row
  typedef struct packed {
    logic [BURST_W-1:0] remaining;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
    logic               proc_class;
  } tbl_entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

@@ design/tlpqs_fifo.sv @@
// Circular slot FIFO in a synchronous RAM with a registered head read.
module tlpqs_fifo import tlpqs_pkg::*; #(
  parameter int unsigned Depth = NUM_PROCS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fifo_ctrl_t                 ctrl_i,
  input  logic [$clog2(Depth)-1:0]   wdata_i,
  output logic [$clog2(Depth)-1:0]   rdata_o,
  output fifo_stat_t                 stat_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [AW-1:0] mem_q [Depth];
  logic [AW-1:0] rdata_q;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CW'(Depth));
  assign do_push      = ctrl_i.push && !stat_o.full;
  assign do_pop       = ctrl_i.pop && !stat_o.empty;
  assign rdata_o      = rdata_q;

  always_comb begin
    head_d = do_pop  ? wrap_inc(head_q) : head_q;
    tail_d = do_push ? wrap_inc(tail_q) : tail_q;
    cnt_d  = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail_q] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[head_q];
    end
  end

endmodule

@@ design/two_level_preemptive_queue_scheduler_top.sv @@
// Top level of the two-level preemptive queue scheduler: process table, FSM, results.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+---------------------
//  request | in        | start high while busy low   | req_i (req_t)
//  result  | out       | res_valid_o, one cycle only | res_o (res_t)
//
// An accepted arrival writes the table and its class FIFO on the accepting edge;
// a dropped one writes neither. Its result shows in the next cycle. A tick request
// runs through accept, select and execute, an order set by two dependent reads of the
// process table RAM: first the running slot's class, then the chosen slot's row.
// An idle tick finishes after select.
// Reset empties both FIFOs, clears the running slot and the tick count; table
// and FIFO RAMs are not cleared, entries are only read after being written.
// The receiver cannot stall results, so busy depends on the request in work only.
module two_level_preemptive_queue_scheduler_top import tlpqs_pkg::*; #(
  parameter int unsigned NUM_PROCS = NUM_PROCS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned SLOT_W = $clog2(NUM_PROCS);

  // FSM codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEL  = 2'd1;
  localparam logic [1:0] S_EXE  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              run_valid_q, run_valid_d;
  logic [SLOT_W-1:0] run_slot_q, run_slot_d;
  logic [TIME_W-1:0] tick_q, tick_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  // process table RAM
  tbl_entry_t        tbl_q [NUM_PROCS];
  tbl_entry_t        tbl_rd_q;
  logic              tbl_we, tbl_re;
  logic [SLOT_W-1:0] tbl_waddr, tbl_raddr;
  tbl_entry_t        tbl_wdata;

  // FIFOs
  fifo_ctrl_t        sys_ctrl, usr_ctrl;
  fifo_stat_t        sys_st, usr_st;
  logic [SLOT_W-1:0] sys_rdata, usr_rdata, usr_wdata, sys_wdata;

  logic              accept;
  logic              id_ok, arr_ok;
  logic [SLOT_W-1:0] req_slot;
  logic              preempt, keep, take_sys, take_usr;
  logic [SLOT_W-1:0] sel_slot;
  logic [TIME_W-1:0] tick_inc, tat, wt;
  logic [BURST_W-1:0] rem_dec;

  tlpqs_fifo #(.Depth(NUM_PROCS)) u_sys_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sys_ctrl),
    .wdata_i (sys_wdata),
    .rdata_o (sys_rdata),
    .stat_o  (sys_st)
  );

  tlpqs_fifo #(.Depth(NUM_PROCS)) u_usr_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (usr_ctrl),
    .wdata_i (usr_wdata),
    .rdata_o (usr_rdata),
    .stat_o  (usr_st)
  );

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // arrival checks: slot in range and class FIFO not full
  assign req_slot = SLOT_W'(req_i.proc_id);
  assign id_ok    = (32'(req_i.proc_id) < 32'(NUM_PROCS));
  assign arr_ok   = id_ok && ((req_i.proc_class == CLS_USR) ? !usr_st.full : !sys_st.full);

  // selection, valid in S_SEL: class of running slot and both FIFO heads are read
  assign preempt  = run_valid_q && (tbl_rd_q.proc_class == CLS_USR) &&
                    !sys_st.empty && !usr_st.full;
  assign keep     = run_valid_q && !preempt;
  assign take_sys = !keep && !sys_st.empty;
  assign take_usr = !keep && sys_st.empty && !usr_st.empty;
  assign sel_slot = keep ? run_slot_q : (take_sys ? sys_rdata : usr_rdata);

  // execute arithmetic: time values modulo 2^32, remaining count saturates at zero
  assign tick_inc = tick_q + TIME_W'(1);
  assign tat      = tick_inc - tbl_rd_q.arrival;
  assign wt       = tat - TIME_W'(tbl_rd_q.burst);
  assign rem_dec  = (tbl_rd_q.remaining == '0) ? '0 : tbl_rd_q.remaining - BURST_W'(1);

  always_comb begin
    state_d     = state_q;
    run_valid_d = run_valid_q;
    run_slot_d  = run_slot_q;
    tick_d      = tick_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    tbl_we      = 1'b0;
    tbl_waddr   = req_slot;
    tbl_wdata   = tbl_rd_q;
    tbl_re      = 1'b0;
    tbl_raddr   = run_slot_q;
    sys_ctrl    = '0;
    usr_ctrl    = '0;
    sys_wdata   = req_slot;
    usr_wdata   = req_slot;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_ARRIVAL) begin
            tbl_we               = arr_ok;
            tbl_wdata.remaining  = req_i.burst;
            tbl_wdata.burst      = req_i.burst;
            tbl_wdata.arrival    = tick_q;
            tbl_wdata.proc_class = req_i.proc_class;
            sys_ctrl.push        = arr_ok && (req_i.proc_class == CLS_SYS);
            usr_ctrl.push        = arr_ok && (req_i.proc_class == CLS_USR);
            res_valid_d          = 1'b1;
            res_d                = '0;
            res_d.status         = arr_ok ? ST_ACCEPT : ST_DROP;
          end else begin
            // read running slot's row and both heads
            tbl_re      = 1'b1;
            sys_ctrl.rd = 1'b1;
            usr_ctrl.rd = 1'b1;
            state_d     = S_SEL;
          end
        end
      end
      S_SEL: begin
        usr_ctrl.push = preempt;
        usr_wdata     = run_slot_q;
        sys_ctrl.pop  = take_sys;
        usr_ctrl.pop  = take_usr;
        run_slot_d    = sel_slot;
        run_valid_d   = keep || take_sys || take_usr;
        if (keep || take_sys || take_usr) begin
          tbl_re    = 1'b1;
          tbl_raddr = sel_slot;
          state_d   = S_EXE;
        end else begin
          tick_d       = tick_inc;
          res_valid_d  = 1'b1;
          res_d        = '0;
          res_d.status = ST_TICK;
          res_d.idle   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_EXE: begin
        tbl_we              = 1'b1;
        tbl_waddr           = run_slot_q;
        tbl_wdata.remaining = rem_dec;
        tick_d              = tick_inc;
        res_valid_d         = 1'b1;
        res_d               = '0;
        res_d.status        = ST_TICK;
        res_d.run_id        = ID_W'(run_slot_q);
        if (rem_dec == '0) begin
          run_valid_d           = 1'b0;
          res_d.done_res        = 1'b1;
          res_d.done_id         = ID_W'(run_slot_q);
          res_d.completion_time = tick_inc;
          res_d.turnaround      = tat;
          res_d.wait_time       = wt;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      tick_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      tick_q      <= tick_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[tbl_waddr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_q[tbl_raddr];
    end
  end

endmodule
